// ===== sv/ebcpu_pkg.sv =====
`default_nettype none
package ebcpu_pkg;

  // Operation codes as carried on the input word
  typedef enum logic [4:0] {
    OP_NOP     = 5'd0,
    OP_HLT     = 5'd1,
    OP_MOV_REG = 5'd2,
    OP_MOV_IMM = 5'd3,
    OP_LOAD    = 5'd4,
    OP_STORE   = 5'd5,
    OP_ADD_REG = 5'd6,
    OP_ADD_IMM = 5'd7,
    OP_SUB_REG = 5'd8,
    OP_SUB_IMM = 5'd9,
    OP_PUSH    = 5'd10,
    OP_POP     = 5'd11,
    OP_JMP     = 5'd12,
    OP_JZ      = 5'd13,
    OP_JNZ     = 5'd14,
    OP_JC      = 5'd15,
    OP_JNC     = 5'd16,
    OP_CALL    = 5'd17,
    OP_RET     = 5'd18,
    OP_BAD     = 5'd31
  } op_e;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 120;

  // Decoded instruction held in the queue
  typedef struct packed {
    op_e         op;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [7:0]  imm;
    logic [15:0] tgt;
    logic [2:0]  len;
    logic [2:0]  cyc;
  } dec_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [31:0] cycle_total;
    logic [31:0] retired_count;
    logic [2:0]  cycles_used;
    logic        fault;
    logic        halted;
    logic        overflow_flag;
    logic        sign_flag;
    logic        carry_flag;
    logic        zero_flag;
    logic [7:0]  written_value;
    logic [15:0] sp_now;
    logic [15:0] pc_next;
  } res_t;

  // Back-end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic halted;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/ebcpu_fifo.sv =====
`default_nettype none
module ebcpu_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ebcpu_pkg::dec_t din_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output ebcpu_pkg::dec_t     dout_o,
  output logic                valid_o
);
  import ebcpu_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  dec_t            slot_q [QDEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= din_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ebcpu_front.sv =====
`default_nettype none
module ebcpu_front (
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [ebcpu_pkg::IN_W-1:0] s_data_i,
  input  wire ebcpu_pkg::stat_t          stat_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output ebcpu_pkg::dec_t                q_data_o
);
  import ebcpu_pkg::*;

  logic [4:0] opc;

  assign opc       = s_data_i[4:0];
  assign s_ready_o = !q_full_i && !stat_i.clearing;
  assign q_push_o  = s_valid_i && s_ready_o;

  // classify: byte length and cycle charge per operation
  always_comb begin
    q_data_o.rd  = s_data_i[7:5];
    q_data_o.rs  = s_data_i[10:8];
    q_data_o.imm = s_data_i[18:11];
    q_data_o.tgt = s_data_i[34:19];
    q_data_o.op  = op_e'(opc);
    q_data_o.len = 3'd3;
    q_data_o.cyc = 3'd3;
    case (opc)
      OP_NOP, OP_HLT: begin
        q_data_o.len = 3'd1;
        q_data_o.cyc = 3'd2;
      end
      OP_MOV_REG, OP_MOV_IMM, OP_ADD_REG, OP_ADD_IMM, OP_SUB_REG, OP_SUB_IMM: begin
        q_data_o.len = 3'd3;
        q_data_o.cyc = 3'd3;
      end
      OP_LOAD, OP_STORE: begin
        q_data_o.len = 3'd4;
        q_data_o.cyc = 3'd5;
      end
      OP_PUSH, OP_POP: begin
        q_data_o.len = 3'd2;
        q_data_o.cyc = 3'd4;
      end
      OP_JMP, OP_JZ, OP_JNZ, OP_JC, OP_JNC: begin
        q_data_o.len = 3'd3;
        q_data_o.cyc = 3'd4;
      end
      OP_CALL: begin
        q_data_o.len = 3'd3;
        q_data_o.cyc = 3'd6;
      end
      OP_RET: begin
        q_data_o.len = 3'd1;
        q_data_o.cyc = 3'd5;
      end
      default: begin
        q_data_o.op  = OP_BAD;
        q_data_o.len = 3'd1;
        q_data_o.cyc = 3'd1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ebcpu_back.sv =====
`default_nettype none
module ebcpu_back #(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire ebcpu_pkg::dec_t q_data_i,
  output logic             q_pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output ebcpu_pkg::res_t  m_data_o,
  output ebcpu_pkg::stat_t stat_o
);
  import ebcpu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_EXEC   = 4'b0100,
    ST_CALLLO = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q;
  dec_t          cur_q;
  logic [7:0]    ra_q, rb_q, rd0_q, rd1_q;
  logic [7:0]    rf_q [8];
  logic [15:0]   pc_q, sp_q;
  logic          z_q, c_q, s_q, o_q, halt_q, err_q;
  logic [31:0]   ret_cnt_q, cyc_tot_q;
  logic          out_valid_q;
  res_t          out_q;

  logic [7:0]  mem [MEM_WORDS];
  logic        mem_we;
  logic [15:0] mem_wa;
  logic [7:0]  mem_wd;
  logic [15:0] ra0, ra1;

  logic        out_free, commit, call_hi;
  logic [7:0]  b_op, wv;
  logic [8:0]  sum9;
  logic [7:0]  dif;
  logic [15:0] ret_addr, pc_n, sp_n;
  logic        z_n, c_n, s_n, o_n, halt_n, err_n, rf_we, cnt_en;
  logic [2:0]  cyc_n;

  assign out_free  = !out_valid_q || m_ready_i;
  assign q_pop_o   = (state_q == ST_ISSUE) && q_valid_i;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;
  assign stat_o    = '{clearing: (state_q == ST_CLEAR), halted: halt_q};

  // read addresses: load target or the two bytes above the stack top
  assign ra0 = (q_data_i.op == OP_LOAD) ? q_data_i.tgt : sp_q + 16'd1;
  assign ra1 = sp_q + 16'd2;

  assign b_op     = (cur_q.op == OP_ADD_IMM || cur_q.op == OP_SUB_IMM) ? cur_q.imm : rb_q;
  assign sum9     = {1'b0, ra_q} + {1'b0, b_op};
  assign dif      = ra_q - b_op;
  assign ret_addr = pc_q + 16'd3;
  assign call_hi  = (cur_q.op == OP_CALL) && !halt_q;
  assign commit   = ((state_q == ST_EXEC) && !call_hi && out_free) ||
                    ((state_q == ST_CALLLO) && out_free);

  // execute
  always_comb begin
    pc_n   = pc_q + {13'd0, cur_q.len};
    sp_n   = sp_q;
    wv     = 8'd0;
    z_n    = z_q;
    c_n    = c_q;
    s_n    = s_q;
    o_n    = o_q;
    halt_n = halt_q;
    err_n  = err_q;
    rf_we  = 1'b0;
    cyc_n  = cur_q.cyc;
    cnt_en = 1'b1;
    case (cur_q.op)
      OP_NOP: ;
      OP_HLT: halt_n = 1'b1;
      OP_MOV_REG: begin
        wv    = rb_q;
        rf_we = 1'b1;
      end
      OP_MOV_IMM: begin
        wv    = cur_q.imm;
        rf_we = 1'b1;
      end
      OP_LOAD: begin
        wv    = rd0_q;
        rf_we = 1'b1;
      end
      OP_STORE: wv = ra_q;
      OP_ADD_REG, OP_ADD_IMM: begin
        wv    = sum9[7:0];
        rf_we = 1'b1;
        z_n   = (sum9[7:0] == 8'd0);
        s_n   = sum9[7];
        c_n   = sum9[8];
        o_n   = (ra_q[7] ^ sum9[7]) & (b_op[7] ^ sum9[7]);
      end
      OP_SUB_REG, OP_SUB_IMM: begin
        wv    = dif;
        rf_we = 1'b1;
        z_n   = (dif == 8'd0);
        s_n   = dif[7];
        c_n   = (ra_q < b_op);
        o_n   = (ra_q[7] ^ b_op[7]) & (ra_q[7] ^ dif[7]);
      end
      OP_PUSH: begin
        wv   = ra_q;
        sp_n = sp_q - 16'd1;
      end
      OP_POP: begin
        wv    = rd0_q;
        rf_we = 1'b1;
        sp_n  = sp_q + 16'd1;
      end
      OP_JMP: pc_n = cur_q.tgt;
      OP_JZ:  if (z_q) pc_n = cur_q.tgt;
      OP_JNZ: if (!z_q) pc_n = cur_q.tgt;
      OP_JC:  if (c_q) pc_n = cur_q.tgt;
      OP_JNC: if (!c_q) pc_n = cur_q.tgt;
      OP_CALL: begin
        pc_n = cur_q.tgt;
        sp_n = sp_q - 16'd2;
        wv   = ret_addr[7:0];
      end
      OP_RET: begin
        pc_n = {rd1_q, rd0_q};
        sp_n = sp_q + 16'd2;
      end
      default: begin
        halt_n = 1'b1;
        err_n  = 1'b1;
        cnt_en = 1'b0;
      end
    endcase
    // halted: report state unchanged, nothing charged
    if (halt_q) begin
      pc_n   = pc_q;
      sp_n   = sp_q;
      wv     = 8'd0;
      z_n    = z_q;
      c_n    = c_q;
      s_n    = s_q;
      o_n    = o_q;
      err_n  = err_q;
      rf_we  = 1'b0;
      cyc_n  = 3'd0;
      cnt_en = 1'b0;
    end
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sp_q;
    mem_wd = 8'd0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = 16'(clr_q);
      end
      ST_EXEC: begin
        if (call_hi) begin
          mem_we = 1'b1;
          mem_wd = ret_addr[15:8];
        end else if (commit && !halt_q && cur_q.op == OP_STORE) begin
          mem_we = 1'b1;
          mem_wa = cur_q.tgt;
          mem_wd = ra_q;
        end else if (commit && !halt_q && cur_q.op == OP_PUSH) begin
          mem_we = 1'b1;
          mem_wd = ra_q;
        end
      end
      ST_CALLLO: begin
        if (commit) begin
          mem_we = 1'b1;
          mem_wa = sp_q - 16'd1;
          mem_wd = ret_addr[7:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa[AW-1:0]] <= mem_wd;
    end
    if (q_pop_o) begin
      rd0_q <= mem[ra0[AW-1:0]];
      rd1_q <= mem[ra1[AW-1:0]];
      ra_q  <= rf_q[q_data_i.rd];
      rb_q  <= rf_q[q_data_i.rs];
      cur_q <= q_data_i;
    end
    if (commit) begin
      out_q <= '{cycle_total: cyc_tot_q + (cnt_en ? {29'd0, cyc_n} : 32'd0),
                 retired_count: ret_cnt_q + (cnt_en ? 32'd1 : 32'd0),
                 cycles_used: cyc_n, fault: err_n, halted: halt_n,
                 overflow_flag: o_n, sign_flag: s_n, carry_flag: c_n,
                 zero_flag: z_n, written_value: wv, sp_now: sp_n,
                 pc_next: pc_n};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == AW'(MEM_WORDS - 1)) state_d = ST_ISSUE;
      ST_ISSUE:  if (q_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (call_hi) begin
          state_d = ST_CALLLO;
        end else if (commit) begin
          state_d = ST_ISSUE;
        end
      end
      ST_CALLLO: if (commit) state_d = ST_ISSUE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pc_q        <= 16'd0;
      sp_q        <= 16'hFFFF;
      z_q         <= 1'b0;
      c_q         <= 1'b0;
      s_q         <= 1'b0;
      o_q         <= 1'b0;
      halt_q      <= 1'b0;
      err_q       <= 1'b0;
      ret_cnt_q   <= 32'd0;
      cyc_tot_q   <= 32'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        rf_q[i] <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (commit) begin
        pc_q        <= pc_n;
        sp_q        <= sp_n;
        z_q         <= z_n;
        c_q         <= c_n;
        s_q         <= s_n;
        o_q         <= o_n;
        halt_q      <= halt_n;
        err_q       <= err_n;
        out_valid_q <= 1'b1;
        if (cnt_en) begin
          ret_cnt_q <= ret_cnt_q + 32'd1;
          cyc_tot_q <= cyc_tot_q + {29'd0, cyc_n};
        end
        if (rf_we) begin
          rf_q[cur_q.rd] <= wv;
        end
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/eight_bit_cpu_execute_step_top.sv =====
// Path: queue slot, operand and memory read registers, result register (call
//   adds the CALLLO state); words go one at a time through the issue/execute
//   pair around the registered byte-memory and register-file reads.
// Reset: rst_ni clears all state at once, then a clearing pass zeroes the
//   whole byte memory; no input word is taken during it.
`default_nettype none
module eight_bit_cpu_execute_step_top #(
  // memory depth, power of two; addresses wrap modulo this
  parameter int unsigned MEM_WORDS = 65536
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // opcode[4:0], dest_reg[7:5], src_reg[10:8], immediate[18:11],
  // target_address[34:19], zero pad[39:35]
  input  wire logic [39:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // pc_next[15:0], sp_now[31:16], written_value[39:32], zero_flag[40],
  // carry_flag[41], sign_flag[42], overflow_flag[43], halted[44], fault[45],
  // cycles_used[48:46], retired_count[80:49], cycle_total[112:81], pad[119:113]
  output logic [119:0]       m_axis_tdata
);
  import ebcpu_pkg::*;

  // front to queue
  logic  q_push, q_full;
  dec_t  q_din;
  // queue to back
  logic  q_valid, q_pop;
  dec_t  q_dout;
  // back status and result
  stat_t st;
  res_t  res;

  // front: takes words, classifies opcode, length and cycle charge
  ebcpu_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .stat_i    (st),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_din)
  );

  // short queue lets front and back stall independently
  ebcpu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .valid_o (q_valid)
  );

  // back: register file, byte memory, flags, counters, output register
  ebcpu_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_dout),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (res),
    .stat_o    (st)
  );

  assign m_axis_tdata = {(OUT_W - $bits(res_t))'(0), res};

`ifndef SYNTHESIS
  // no word taken while the memory is being cleared
  a_no_take_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.clearing |-> !s_axis_tready) else $error("word taken during clear");

  // halt is sticky
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.halted |=> st.halted) else $error("halt mark dropped");

  // a fault always comes with halt
  a_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[45]) |-> m_axis_tdata[44])
    else $error("fault without halt");

  // a zero cycle charge only while halted
  a_zero_cyc_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[48:46] == 3'd0) |-> m_axis_tdata[44])
    else $error("zero cycle charge on running machine");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ebcpu_pkg::*;

  localparam int unsigned N_RANDOM = 850;
  localparam int unsigned N_OPEN   = 25;     // rows driven before the random part
  localparam int unsigned N_AFTER  = 12;     // random words driven once halted
  localparam int unsigned STALL_PCT = 38;
  // Longest quiet spell is the memory clearing pass after reset
  localparam int unsigned WATCHDOG = 4 * 65536;

  typedef struct {
    logic [4:0]  op;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [7:0]  imm;
    logic [15:0] tgt;
    bit          known;  // want holds a hand-written result
    res_t        want;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // opcode, dest_reg, src_reg, immediate, target_address, pad
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pc_next, sp_now, written_value, Z, C, S, O, halted, fault,
  // cycles_used, retired_count, cycle_total, pad
  logic [119:0] m_axis_tdata;

  eight_bit_cpu_execute_step_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // CPU state as this bench sees it
  bit [7:0]  cpu_regs [8];
  bit [7:0]  cpu_mem [65536];
  bit [15:0] cpu_pc = '0;
  bit [15:0] cpu_sp = 16'hFFFF;
  bit        fz, fc, fs, fo;
  bit        cpu_halt, cpu_err;
  bit [31:0] retired_cnt = '0;
  bit [31:0] cycle_cnt = '0;

  res_t      pending_res[$];
  stim_row_t dir_tab[$];
  logic [4:0] prev_op = OP_NOP;
  int unsigned n_sent, n_checked, n_fail, n_taken, n_calls;

  // No idling on either side through this window
  wire calm_in  = (n_sent >= 400) && (n_sent < 560);
  wire calm_out = (n_checked >= 400) && (n_checked < 560);

  function automatic logic [7:0] alu(bit minus, logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s  = minus ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, b};
    fz = (s[7:0] == 8'h00);
    fs = s[7];
    fc = minus ? (a < b) : s[8];
    fo = minus ? (a[7] != b[7]) && (s[7] != a[7]) : (a[7] == b[7]) && (s[7] != a[7]);
    return s[7:0];
  endfunction

  // Applies one instruction to the state and returns the result word
  function automatic res_t exec_instr(logic [4:0] op, logic [2:0] rd, logic [2:0] rs,
                                      logic [7:0] imm, logic [15:0] tgt);
    res_t        r;
    logic [7:0]  wv;
    logic [7:0]  lo;
    logic [2:0]  cyc;
    logic [15:0] len;
    logic [15:0] dest;
    logic [15:0] ret_addr;
    bit          jump;
    wv = '0;
    cyc = '0;
    len = 16'd1;
    dest = tgt;
    jump = 1'b0;
    if (!cpu_halt) begin
      case (op)
        OP_NOP: cyc = 3'd2;
        OP_HLT: begin
          cpu_halt = 1'b1;
          cyc = 3'd2;
        end
        OP_MOV_REG, OP_MOV_IMM: begin
          wv = (op == OP_MOV_REG) ? cpu_regs[rs] : imm;
          cpu_regs[rd] = wv;
          len = 16'd3;
          cyc = 3'd3;
        end
        OP_LOAD: begin
          wv = cpu_mem[tgt];
          cpu_regs[rd] = wv;
          len = 16'd4;
          cyc = 3'd5;
        end
        OP_STORE: begin
          wv = cpu_regs[rd];
          cpu_mem[tgt] = wv;
          len = 16'd4;
          cyc = 3'd5;
        end
        OP_ADD_REG, OP_ADD_IMM, OP_SUB_REG, OP_SUB_IMM: begin
          wv = alu(op == OP_SUB_REG || op == OP_SUB_IMM, cpu_regs[rd],
                   (op == OP_ADD_REG || op == OP_SUB_REG) ? cpu_regs[rs] : imm);
          cpu_regs[rd] = wv;
          len = 16'd3;
          cyc = 3'd3;
        end
        OP_PUSH: begin
          wv = cpu_regs[rd];
          cpu_mem[cpu_sp] = wv;
          cpu_sp--;
          len = 16'd2;
          cyc = 3'd4;
        end
        OP_POP: begin
          cpu_sp++;
          wv = cpu_mem[cpu_sp];
          cpu_regs[rd] = wv;
          len = 16'd2;
          cyc = 3'd4;
        end
        OP_JMP, OP_JZ, OP_JNZ, OP_JC, OP_JNC: begin
          case (op)
            OP_JMP: jump = 1'b1;
            OP_JZ:  jump = fz;
            OP_JNZ: jump = !fz;
            OP_JC:  jump = fc;
            default: jump = !fc;
          endcase
          len = 16'd3;
          cyc = 3'd4;
        end
        OP_CALL: begin
          // return address high byte goes in first, so low byte ends up lower
          ret_addr = cpu_pc + 16'd3;
          cpu_mem[cpu_sp] = ret_addr[15:8];
          cpu_sp--;
          wv = ret_addr[7:0];
          cpu_mem[cpu_sp] = wv;
          cpu_sp--;
          jump = 1'b1;
          cyc = 3'd6;
          n_calls++;
        end
        OP_RET: begin
          cpu_sp++;
          lo = cpu_mem[cpu_sp];
          cpu_sp++;
          dest = {cpu_mem[cpu_sp], lo};
          jump = 1'b1;
          cyc = 3'd5;
        end
        default: begin
          // undefined code: stop with the fault mark, counters untouched
          cpu_err = 1'b1;
          cpu_halt = 1'b1;
          cyc = 3'd1;
        end
      endcase
      cpu_pc = jump ? dest : cpu_pc + len;
      if (jump) n_taken++;
      if (op <= OP_RET) begin
        retired_cnt++;
        cycle_cnt += cyc;
      end
    end
    r = '0;
    r.pc_next = cpu_pc;
    r.sp_now = cpu_sp;
    r.written_value = wv;
    r.zero_flag = fz;
    r.carry_flag = fc;
    r.sign_flag = fs;
    r.overflow_flag = fo;
    r.halted = cpu_halt;
    r.fault = cpu_err;
    r.cycles_used = cyc;
    r.retired_count = retired_cnt;
    r.cycle_total = cycle_cnt;
    return r;
  endfunction

  // flags as {O, S, C, Z}; halt bits as {fault, halted}
  function automatic res_t res_of(logic [15:0] pc, logic [15:0] sp, logic [7:0] wv,
                                  logic [3:0] oscz, logic [1:0] hf, logic [2:0] cyc,
                                  logic [31:0] ret, logic [31:0] tot);
    res_t r;
    r = '0;
    r.pc_next = pc;
    r.sp_now = sp;
    r.written_value = wv;
    {r.overflow_flag, r.sign_flag, r.carry_flag, r.zero_flag} = oscz;
    {r.fault, r.halted} = hf;
    r.cycles_used = cyc;
    r.retired_count = ret;
    r.cycle_total = tot;
    return r;
  endfunction

  function automatic stim_row_t srow(logic [4:0] op, logic [2:0] rd, logic [2:0] rs,
                                     logic [7:0] imm, logic [15:0] tgt,
                                     bit known = 1'b0, res_t want = '0);
    stim_row_t r;
    r.op = op;
    r.rd = rd;
    r.rs = rs;
    r.imm = imm;
    r.tgt = tgt;
    r.known = known;
    r.want = want;
    return r;
  endfunction

  // Random instruction; undefined codes and halt only once halted
  function automatic stim_row_t rand_row(bit any_op);
    stim_row_t  r;
    int unsigned k;
    r = srow(OP_NOP, 3'($urandom_range(7)), 3'($urandom_range(7)), 8'($urandom), 16'h0);
    k = $urandom_range(17);
    r.op = (k == 0) ? 5'(OP_NOP) : 5'(k + 1);
    if (prev_op == OP_CALL && $urandom_range(2) == 0) r.op = OP_RET;
    if (any_op) r.op = 5'($urandom_range(31));
    case ($urandom_range(7))
      0: r.imm = 8'h00;
      1: r.imm = 8'hFF;
      2: r.imm = 8'h80;
      3: r.imm = 8'h7F;
      default: ;
    endcase
    // keep most addresses in two small windows so stores, loads and the
    // stack keep hitting each other
    case ($urandom_range(3))
      0: r.tgt = 16'($urandom);
      1: r.tgt = {12'hFFF, 4'($urandom_range(15))};
      default: r.tgt = {12'h000, 4'($urandom_range(15))};
    endcase
    prev_op = r.op;
    return r;
  endfunction

  task automatic issue(stim_row_t row);
    res_t guess;
    while (!calm_in && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, row.tgt, row.imm, row.rs, row.rd, row.op};
    do @(posedge clk_i); while (!s_axis_tready);
    guess = exec_instr(row.op, row.rd, row.rs, row.imm, row.tgt);
    pending_res.push_back(row.known ? row.want : guess);
    n_sent++;
  endtask

  task automatic note_bad(string what, logic [31:0] want, logic [31:0] got);
    n_fail++;
    if (n_fail <= 10)
      $display("mismatch in %s on word %0d: expected %0h, got %0h", what, n_checked, want,
               got);
  endtask

  task automatic check_word(logic [119:0] data);
    res_t got;
    res_t want;
    got = res_t'(data[112:0]);
    if (pending_res.size() == 0) begin
      note_bad("unexpected result word", 32'h0, got.pc_next);
    end else begin
      want = pending_res.pop_front();
      if (got.pc_next !== want.pc_next) note_bad("pc_next", want.pc_next, got.pc_next);
      if (got.sp_now !== want.sp_now) note_bad("sp_now", want.sp_now, got.sp_now);
      if (got.written_value !== want.written_value)
        note_bad("written_value", want.written_value, got.written_value);
      if (got.zero_flag !== want.zero_flag)
        note_bad("zero_flag", want.zero_flag, got.zero_flag);
      if (got.carry_flag !== want.carry_flag)
        note_bad("carry_flag", want.carry_flag, got.carry_flag);
      if (got.sign_flag !== want.sign_flag)
        note_bad("sign_flag", want.sign_flag, got.sign_flag);
      if (got.overflow_flag !== want.overflow_flag)
        note_bad("overflow_flag", want.overflow_flag, got.overflow_flag);
      if (got.halted !== want.halted) note_bad("halted", want.halted, got.halted);
      if (got.fault !== want.fault) note_bad("fault", want.fault, got.fault);
      if (got.cycles_used !== want.cycles_used)
        note_bad("cycles_used", want.cycles_used, got.cycles_used);
      if (got.retired_count !== want.retired_count)
        note_bad("retired_count", want.retired_count, got.retired_count);
      if (got.cycle_total !== want.cycle_total)
        note_bad("cycle_total", want.cycle_total, got.cycle_total);
    end
    n_checked++;
  endtask

  // Result side: check what was taken at this edge, then choose the next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
      m_axis_tready <= calm_out || ($urandom_range(99) >= STALL_PCT);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: nothing moved for %0d cycles, %0d words sent, %0d checked",
               quiet_cycles, n_sent, n_checked);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    // Opening rows: the first four are plain enough to write out by hand
    dir_tab.push_back(srow(OP_NOP, 3'd0, 3'd0, 8'h00, 16'h0000, 1'b1,
      res_of(16'd1, 16'hFFFF, 8'h00, 4'b0000, 2'b00, 3'd2, 32'd1, 32'd2)));
    dir_tab.push_back(srow(OP_MOV_IMM, 3'd0, 3'd0, 8'hFF, 16'h0000, 1'b1,
      res_of(16'd4, 16'hFFFF, 8'hFF, 4'b0000, 2'b00, 3'd3, 32'd2, 32'd5)));
    // FF + 1: zero with carry out
    dir_tab.push_back(srow(OP_ADD_IMM, 3'd0, 3'd0, 8'h01, 16'h0000, 1'b1,
      res_of(16'd7, 16'hFFFF, 8'h00, 4'b0011, 2'b00, 3'd3, 32'd3, 32'd8)));
    // 0 - 1: borrow, negative
    dir_tab.push_back(srow(OP_SUB_IMM, 3'd1, 3'd0, 8'h01, 16'h0000, 1'b1,
      res_of(16'd10, 16'hFFFF, 8'hFF, 4'b0110, 2'b00, 3'd3, 32'd4, 32'd11)));
    dir_tab.push_back(srow(OP_MOV_IMM, 3'd2, 3'd0, 8'h7F, 16'h0000));
    dir_tab.push_back(srow(OP_ADD_IMM, 3'd2, 3'd0, 8'h01, 16'h0000));  // signed overflow up
    dir_tab.push_back(srow(OP_SUB_IMM, 3'd2, 3'd0, 8'h01, 16'h0000));  // and back down
    dir_tab.push_back(srow(OP_MOV_REG, 3'd7, 3'd1, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_STORE, 3'd7, 3'd0, 8'h00, 16'hFFFF));
    dir_tab.push_back(srow(OP_LOAD, 3'd4, 3'd0, 8'h00, 16'hFFFF));
    dir_tab.push_back(srow(OP_STORE, 3'd2, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_PUSH, 3'd7, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_POP, 3'd6, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_POP, 3'd5, 3'd0, 8'h00, 16'h0000));    // SP wraps to 0000
    dir_tab.push_back(srow(OP_JZ, 3'd0, 3'd0, 8'h00, 16'h1234));
    dir_tab.push_back(srow(OP_JNZ, 3'd0, 3'd0, 8'h00, 16'h1234));
    dir_tab.push_back(srow(OP_JC, 3'd0, 3'd0, 8'h00, 16'hABCD));
    dir_tab.push_back(srow(OP_JNC, 3'd0, 3'd0, 8'h00, 16'hABCD));
    dir_tab.push_back(srow(OP_SUB_REG, 3'd3, 3'd7, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_JC, 3'd0, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_ADD_REG, 3'd0, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_JZ, 3'd0, 3'd0, 8'h00, 16'hFFFD));
    // return address FFFD + 3 wraps to 0000, pushed across the SP wrap
    dir_tab.push_back(srow(OP_CALL, 3'd0, 3'd0, 8'h00, 16'hFFFF));
    dir_tab.push_back(srow(OP_RET, 3'd0, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_JMP, 3'd0, 3'd0, 8'h00, 16'h8000));
    // Closing rows: only one stop is possible per reset, so the undefined
    // code takes it and halt is seen only while already stopped
    dir_tab.push_back(srow(OP_BAD, 3'd7, 3'd7, 8'hFF, 16'hFFFF));
    dir_tab.push_back(srow(OP_HLT, 3'd0, 3'd0, 8'h00, 16'h0000));
    dir_tab.push_back(srow(OP_MOV_IMM, 3'd0, 3'd0, 8'h55, 16'h0000));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < N_OPEN; k++) issue(dir_tab[k]);
    for (k = 0; k < N_RANDOM; k++) issue(rand_row(1'b0));
    for (k = N_OPEN; k < dir_tab.size(); k++) issue(dir_tab[k]);
    for (k = 0; k < N_AFTER; k++) issue(rand_row(1'b1));
    s_axis_tvalid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (pending_res.size() != 0) note_bad("results still owed", 32'h0, pending_res.size());

    $display("covered %0d instructions (%0d hand-picked), %0d result words compared",
             n_sent, dir_tab.size(), n_checked);
    $display("%0d taken jumps, calls and returns, %0d calls; stopped on an undefined code",
             n_taken, n_calls);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", n_fail);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== eight_bit_cpu_execute_step_top.f =====
sv/ebcpu_pkg.sv
sv/ebcpu_fifo.sv
sv/ebcpu_front.sv
sv/ebcpu_back.sv
sv/eight_bit_cpu_execute_step_top.sv
test/tb.sv
